### rtl/slim_pkg.sv
package slim_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEFF_BITS_DEF  = 16;

   localparam int RATIO_W   = 16;
   localparam int GAIN_W    = 17;
   localparam int INDEX_W   = 2;

   // shared multiplier operand and product widths
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // log2 datapath: mantissa normalized in a 32-bit word, Q5.16 result
   localparam int LOG_W   = 32;
   localparam int EXP_W   = 5;
   localparam int FRAC_W  = 16;
   localparam int LVAL_W  = EXP_W + FRAC_W;

   // slope divider: 2^24 / ratio, one quotient bit per cycle
   localparam int DIV_TOP = 24;
   localparam int QUO_W   = DIV_TOP + 1;
   localparam int REM_W   = RATIO_W + 1;

   // integer square root unit
   localparam int SQ_W    = 62;
   localparam int SQ_TOP  = SQ_W - 2;
   localparam int ROOT_W  = 31;

   localparam logic [INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_ATTACK    = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_RELEASE   = 2'd2;
   localparam logic [INDEX_W-1:0] CSR_RATIO     = 2'd3;

   localparam int THRESHOLD_RESET = 4194304;
   localparam int ATTACK_RESET    = 58982;
   localparam int RELEASE_RESET   = 65208;
   localparam int RATIO_RESET     = 2560;
   localparam int RATIO_MIN       = 256;
   localparam int GAIN_UNITY      = 65536;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ABS,
      S_ENV_A,
      S_ENV_B,
      S_ENV_C,
      S_CMP,
      S_DIV,
      S_NORM,
      S_LOG_MUL,
      S_LOG_BIT,
      S_ATT_MUL,
      S_ATT_RND,
      S_SQ_START,
      S_SQ_WAIT,
      S_GAIN,
      S_OUT_MUL,
      S_OUT_LOAD
   } state_type;

   function automatic int max3(input int a, input int b, input int c);
      int m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

endpackage

### rtl/slim_isqrt.sv
module slim_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [slim_pkg::SQ_W-1:0]    value,
   output logic                         busy,
   output logic [slim_pkg::ROOT_W-1:0]  root
);

   logic [slim_pkg::SQ_W-1:0] v_ff, v_in;
   logic [slim_pkg::SQ_W-1:0] r_ff, r_in;
   logic [slim_pkg::SQ_W-1:0] bit_ff, bit_in;
   logic [slim_pkg::SQ_W-1:0] trial;

   always_comb begin
      trial  = r_ff + bit_ff;
      v_in   = v_ff;
      r_in   = r_ff;
      bit_in = bit_ff;
      if (start) begin
         v_in   = value;
         r_in   = '0;
         bit_in = slim_pkg::SQ_W'(1) << slim_pkg::SQ_TOP;
      end else if (bit_ff != '0) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      r_ff <= r_in;
   end

   assign busy = (bit_ff != '0);
   assign root = r_ff[slim_pkg::ROOT_W-1:0];

endmodule

### rtl/soft_limiter_envelope_gain.sv
// Unity-gain samples (envelope at or below threshold) skip the divider, log2 and square root steps.
// Limited samples run the slope divider, two 16-step log2 squarings and sixteen
// passes through the bit-serial square root.
// One transaction at a time; a new sample is taken only once the last result is in the
// output register, and the output step waits while a held result is still stalled.
// Synchronous reset restores register defaults and clears the envelope to zero.
module soft_limiter_envelope_gain #(
   parameter int SAMPLE_BITS = slim_pkg::SAMPLE_BITS_DEF,
   parameter int COEFF_BITS  = slim_pkg::COEFF_BITS_DEF,
   localparam int CsrW = slim_pkg::max3(SAMPLE_BITS - 1, COEFF_BITS, slim_pkg::RATIO_W)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic [slim_pkg::GAIN_W-1:0]        rsp_gain_applied,
   input  logic                               csr_wen,
   input  logic [slim_pkg::INDEX_W-1:0]       csr_index,
   input  logic [CsrW-1:0]                    csr_data
);

   localparam int ThrW = SAMPLE_BITS - 1;
   localparam int AccW = SAMPLE_BITS + COEFF_BITS + 1;
   localparam int PW   = slim_pkg::PROD_W;
   localparam logic [COEFF_BITS:0] CoefOne  = (COEFF_BITS + 1)'(1) << COEFF_BITS;
   localparam logic [AccW-1:0]     AccHalf  = AccW'(1) << (COEFF_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] EnvMax = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic signed [PW-1:0] SatHi = (PW'(1) <<< (SAMPLE_BITS - 1)) - PW'(1);
   localparam logic signed [PW-1:0] SatLo = -SatHi - PW'(1);
   localparam logic signed [PW-1:0] RndHalf = PW'(32768);

   // configuration registers
   logic [ThrW-1:0]                 thr_ff;
   logic [COEFF_BITS-1:0]           att_coef_ff;
   logic [COEFF_BITS-1:0]           rel_coef_ff;
   logic [slim_pkg::RATIO_W-1:0]    ratio_ff;

   slim_pkg::state_type             state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0]   sample_ff, sample_in;
   logic [SAMPLE_BITS-1:0]          mag_ff, mag_in;
   logic [COEFF_BITS-1:0]           coef_ff, coef_in;
   logic [SAMPLE_BITS-1:0]          env_ff, env_in;
   logic [AccW-1:0]                 acc_ff, acc_in;
   logic signed [PW-1:0]            prod_ff, prod_in;
   logic [slim_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [slim_pkg::QUO_W-1:0]      quo_ff, quo_in;
   logic [4:0]                      dcnt_ff, dcnt_in;
   logic [slim_pkg::GAIN_W-1:0]     slope_ff, slope_in;
   logic [slim_pkg::LOG_W-1:0]      w_ff, w_in;
   logic [slim_pkg::EXP_W-1:0]      sh_ff, sh_in;
   logic [slim_pkg::LOG_W-1:0]      m_ff, m_in;
   logic [slim_pkg::FRAC_W-1:0]     frac_ff, frac_in;
   logic [3:0]                      kcnt_ff, kcnt_in;
   logic                            second_ff, second_in;
   logic [slim_pkg::LVAL_W-1:0]     le_ff, le_in;
   logic [slim_pkg::LVAL_W-1:0]     d_ff, d_in;
   logic [slim_pkg::LVAL_W-1:0]     att_ff, att_in;
   logic [slim_pkg::ROOT_W-1:0]     y_ff, y_in;
   logic [slim_pkg::GAIN_W-1:0]     gain_ff, gain_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]   rsp_sample_ff, rsp_sample_in;
   logic [slim_pkg::GAIN_W-1:0]     rsp_gain_ff, rsp_gain_in;

   logic signed [slim_pkg::MUL_W-1:0] mul_a, mul_b;
   logic [SAMPLE_BITS-1:0]          mag_abs;
   logic [ThrW-1:0]                 thr_eff;
   logic [slim_pkg::RATIO_W-1:0]    ratio_eff;
   logic [slim_pkg::REM_W-1:0]      rem_shift;
   logic                            qbit;
   logic [slim_pkg::QUO_W-1:0]      quo_full;
   logic [slim_pkg::LOG_W-1:0]      sq_t;
   logic                            lbit;
   logic [slim_pkg::FRAC_W-1:0]     frac_next;
   logic [slim_pkg::LVAL_W-1:0]     log_val;
   logic [slim_pkg::LVAL_W:0]       att_sum;
   logic [63:0]                     gsum;
   logic [slim_pkg::EXP_W-1:0]      exp_n;
   logic [slim_pkg::FRAC_W-1:0]     att_frac;
   logic signed [PW-1:0]            rnd;
   logic                            sq_start;
   logic [slim_pkg::SQ_W-1:0]       sq_value;
   logic                            sq_busy;
   logic [slim_pkg::ROOT_W-1:0]     sq_root;

   slim_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_value),
      .busy  (sq_busy),
      .root  (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= ThrW'(slim_pkg::THRESHOLD_RESET);
         att_coef_ff <= COEFF_BITS'(slim_pkg::ATTACK_RESET);
         rel_coef_ff <= COEFF_BITS'(slim_pkg::RELEASE_RESET);
         ratio_ff    <= slim_pkg::RATIO_W'(slim_pkg::RATIO_RESET);
      end else if (csr_wen) begin
         case (csr_index)
            slim_pkg::CSR_THRESHOLD: thr_ff      <= csr_data[ThrW-1:0];
            slim_pkg::CSR_ATTACK:    att_coef_ff <= csr_data[COEFF_BITS-1:0];
            slim_pkg::CSR_RELEASE:   rel_coef_ff <= csr_data[COEFF_BITS-1:0];
            slim_pkg::CSR_RATIO:     ratio_ff    <= csr_data[slim_pkg::RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      mag_abs   = sample_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_ff) : SAMPLE_BITS'(sample_ff);
      thr_eff   = (thr_ff == '0) ? ThrW'(1) : thr_ff;
      ratio_eff = (ratio_ff < slim_pkg::RATIO_W'(slim_pkg::RATIO_MIN))
                  ? slim_pkg::RATIO_W'(slim_pkg::RATIO_MIN) : ratio_ff;
      rem_shift = {rem_ff[slim_pkg::REM_W-2:0], (dcnt_ff == 5'(slim_pkg::DIV_TOP))};
      qbit      = (rem_shift >= {1'b0, ratio_eff});
      quo_full  = {quo_ff[slim_pkg::QUO_W-2:0], qbit};
      sq_t      = prod_ff[61:30];
      lbit      = sq_t[slim_pkg::LOG_W-1];
      frac_next = {frac_ff[slim_pkg::FRAC_W-2:0], lbit};
      log_val   = {5'(31) - sh_ff, frac_next};
      att_sum   = (slim_pkg::LVAL_W + 1)'((prod_ff[37:0] + 38'd32768) >> 16);
      exp_n     = att_ff[slim_pkg::LVAL_W-1:slim_pkg::FRAC_W];
      att_frac  = att_ff[slim_pkg::FRAC_W-1:0];
      gsum      = 64'(y_ff) + (64'd1 << (13 + int'(exp_n)));
      rnd       = (prod_ff + RndHalf) >>> 16;
      sq_value  = att_frac[kcnt_ff] ? (slim_pkg::SQ_W'(y_ff) << 29)
                                    : (slim_pkg::SQ_W'(y_ff) << 30);

      state_in      = state_ff;
      sample_in     = sample_ff;
      mag_in        = mag_ff;
      coef_in       = coef_ff;
      env_in        = env_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dcnt_in       = dcnt_ff;
      slope_in      = slope_ff;
      w_in          = w_ff;
      sh_in         = sh_ff;
      m_in          = m_ff;
      frac_in       = frac_ff;
      kcnt_in       = kcnt_ff;
      second_in     = second_ff;
      le_in         = le_ff;
      d_in          = d_ff;
      att_in        = att_ff;
      y_in          = y_ff;
      gain_in       = gain_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_gain_in   = rsp_gain_ff;
      mul_a         = '0;
      mul_b         = '0;
      sq_start      = 1'b0;

      case (state_ff)
         slim_pkg::S_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample_in;
               state_in  = slim_pkg::S_ABS;
            end
         end
         slim_pkg::S_ABS: begin
            mag_in   = mag_abs;
            coef_in  = (mag_abs > env_ff) ? att_coef_ff : rel_coef_ff;
            state_in = slim_pkg::S_ENV_A;
         end
         slim_pkg::S_ENV_A: begin
            mul_a    = slim_pkg::MUL_W'(coef_ff);
            mul_b    = slim_pkg::MUL_W'(env_ff);
            state_in = slim_pkg::S_ENV_B;
         end
         slim_pkg::S_ENV_B: begin
            acc_in   = prod_ff[AccW-1:0];
            mul_a    = slim_pkg::MUL_W'(CoefOne - (COEFF_BITS + 1)'(coef_ff));
            mul_b    = slim_pkg::MUL_W'(mag_ff);
            state_in = slim_pkg::S_ENV_C;
         end
         slim_pkg::S_ENV_C: begin
            env_in   = SAMPLE_BITS'((acc_ff + prod_ff[AccW-1:0] + AccHalf) >> COEFF_BITS);
            state_in = slim_pkg::S_CMP;
         end
         slim_pkg::S_CMP: begin
            if (env_ff > SAMPLE_BITS'(thr_eff)) begin
               rem_in   = '0;
               quo_in   = '0;
               dcnt_in  = 5'(slim_pkg::DIV_TOP);
               state_in = slim_pkg::S_DIV;
            end else begin
               gain_in  = slim_pkg::GAIN_W'(slim_pkg::GAIN_UNITY);
               state_in = slim_pkg::S_OUT_MUL;
            end
         end
         slim_pkg::S_DIV: begin
            rem_in = qbit ? (rem_shift - {1'b0, ratio_eff}) : rem_shift;
            quo_in = quo_full;
            if (dcnt_ff == '0) begin
               slope_in  = slim_pkg::GAIN_W'(slim_pkg::QUO_W'(slim_pkg::GAIN_UNITY) - quo_full);
               w_in      = slim_pkg::LOG_W'(env_ff);
               sh_in     = '0;
               second_in = 1'b0;
               state_in  = slim_pkg::S_NORM;
            end else begin
               dcnt_in = dcnt_ff - 5'd1;
            end
         end
         slim_pkg::S_NORM: begin
            // one bit of leading-zero shift per cycle
            if (w_ff[slim_pkg::LOG_W-1]) begin
               m_in     = w_ff >> 1;
               frac_in  = '0;
               kcnt_in  = '0;
               state_in = slim_pkg::S_LOG_MUL;
            end else begin
               w_in  = w_ff << 1;
               sh_in = sh_ff + 5'd1;
            end
         end
         slim_pkg::S_LOG_MUL: begin
            mul_a    = slim_pkg::MUL_W'(m_ff);
            mul_b    = slim_pkg::MUL_W'(m_ff);
            state_in = slim_pkg::S_LOG_BIT;
         end
         slim_pkg::S_LOG_BIT: begin
            m_in    = lbit ? (sq_t >> 1) : sq_t;
            frac_in = frac_next;
            if (kcnt_ff == 4'd15) begin
               if (!second_ff) begin
                  le_in     = log_val;
                  w_in      = slim_pkg::LOG_W'(thr_eff);
                  sh_in     = '0;
                  second_in = 1'b1;
                  state_in  = slim_pkg::S_NORM;
               end else begin
                  d_in     = (le_ff > log_val) ? (le_ff - log_val) : '0;
                  state_in = slim_pkg::S_ATT_MUL;
               end
            end else begin
               kcnt_in  = kcnt_ff + 4'd1;
               state_in = slim_pkg::S_LOG_MUL;
            end
         end
         slim_pkg::S_ATT_MUL: begin
            mul_a    = slim_pkg::MUL_W'(d_ff);
            mul_b    = slim_pkg::MUL_W'(slope_ff);
            state_in = slim_pkg::S_ATT_RND;
         end
         slim_pkg::S_ATT_RND: begin
            att_in   = att_sum[slim_pkg::LVAL_W-1:0];
            y_in     = slim_pkg::ROOT_W'(1) << 30;
            kcnt_in  = '0;
            state_in = slim_pkg::S_SQ_START;
         end
         slim_pkg::S_SQ_START: begin
            // fraction bits of the attenuation, lsb first
            sq_start = 1'b1;
            state_in = slim_pkg::S_SQ_WAIT;
         end
         slim_pkg::S_SQ_WAIT: begin
            if (!sq_busy) begin
               y_in = sq_root;
               if (kcnt_ff == 4'd15) begin
                  state_in = slim_pkg::S_GAIN;
               end else begin
                  kcnt_in  = kcnt_ff + 4'd1;
                  state_in = slim_pkg::S_SQ_START;
               end
            end
         end
         slim_pkg::S_GAIN: begin
            gain_in  = slim_pkg::GAIN_W'(gsum >> (14 + int'(exp_n)));
            state_in = slim_pkg::S_OUT_MUL;
         end
         slim_pkg::S_OUT_MUL: begin
            mul_a    = slim_pkg::MUL_W'(sample_ff);
            mul_b    = slim_pkg::MUL_W'(gain_ff);
            state_in = slim_pkg::S_OUT_LOAD;
         end
         slim_pkg::S_OUT_LOAD: begin
            mul_a = slim_pkg::MUL_W'(sample_ff);
            mul_b = slim_pkg::MUL_W'(gain_ff);
            // wait while the previous transaction is still held at the output
            if (!(rsp_valid_ff && rsp_stall)) begin
               if (rnd > SatHi) begin
                  rsp_sample_in = SAMPLE_BITS'(SatHi);
               end else if (rnd < SatLo) begin
                  rsp_sample_in = SAMPLE_BITS'(SatLo);
               end else begin
                  rsp_sample_in = SAMPLE_BITS'(rnd);
               end
               rsp_gain_in  = gain_ff;
               rsp_valid_in = 1'b1;
               state_in     = slim_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = slim_pkg::S_IDLE;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slim_pkg::S_IDLE;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      mag_ff        <= mag_in;
      coef_ff       <= coef_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dcnt_ff       <= dcnt_in;
      slope_ff      <= slope_in;
      w_ff          <= w_in;
      sh_ff         <= sh_in;
      m_ff          <= m_in;
      frac_ff       <= frac_in;
      kcnt_ff       <= kcnt_in;
      second_ff     <= second_in;
      le_ff         <= le_in;
      d_ff          <= d_in;
      att_ff        <= att_in;
      y_ff          <= y_in;
      gain_ff       <= gain_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_gain_ff   <= rsp_gain_in;
   end

   assign req_stall        = (state_ff != slim_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_out   = rsp_sample_ff;
   assign rsp_gain_applied = rsp_gain_ff;

   envelope_bounded: assert property (@(posedge clock) disable iff (reset)
      env_ff <= EnvMax)
      else $error("envelope above full-scale magnitude");

   gain_not_above_unity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain_applied <= slim_pkg::GAIN_W'(slim_pkg::GAIN_UNITY))
      else $error("gain above unity");

   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !sq_busy)
      else $error("not busy after transaction accepted");

   root_idle_outside_exp: assert property (@(posedge clock) disable iff (reset)
      sq_busy |-> state_ff == slim_pkg::S_SQ_WAIT)
      else $error("square root running outside exp2 step");

endmodule

### verif/soft_limiter_envelope_gain_tb.sv
module soft_limiter_envelope_gain_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW    = slim_pkg::SAMPLE_BITS_DEF;
   localparam int CSR_W = 23;
   localparam int SMAX  = (1 << (SW - 1)) - 1;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic signed [SW-1:0]          smp;
      bit                            typed;
      logic signed [SW-1:0]          out;
      logic [slim_pkg::GAIN_W-1:0]   gain;
   } stim_row_type;

   typedef struct {
      logic signed [SW-1:0]          out;
      logic [slim_pkg::GAIN_W-1:0]   gain;
   } limited_sample_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic signed [SW-1:0]            req_sample_in = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic signed [SW-1:0]            rsp_sample_out;
   logic [slim_pkg::GAIN_W-1:0]     rsp_gain_applied;
   logic                            csr_wen = 1'b0;
   logic [slim_pkg::INDEX_W-1:0]    csr_index = slim_pkg::CSR_THRESHOLD;
   logic [CSR_W-1:0]                csr_data = '0;

   soft_limiter_envelope_gain dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [22:0]      thr_reg;
   logic [15:0]      attack_reg, release_reg, ratio_reg;
   longint unsigned  env_level;

   limited_sample_type  expected_q[$];
   stim_row_type        directed_rows[$];

   bit                           cur_typed = 1'b0;
   logic signed [SW-1:0]         cur_out = '0;
   logic [slim_pkg::GAIN_W-1:0]  cur_gain = '0;

   int  send_pct = 0, stall_pct = 0;
   bit  hold_request = 1'b0;
   int  errors = 0, accepted = 0, checked = 0, limited = 0;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Q8.16 log2 by repeated squaring of the normalized mantissa
   function automatic longint unsigned fixed_log2(input longint unsigned x);
      int unsigned     e;
      longint unsigned m, frac;
      e = 0;
      frac = 0;
      if (x == 0) x = 1;
      while (e < 62 && (x >> (e + 1)) != 0) e++;
      m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 30;
         frac <<= 1;
         if (m >= (64'd1 << 31)) begin
            frac |= 1;
            m >>= 1;
         end
      end
      return (longint'(e) << 16) | frac;
   endfunction

   function automatic longint unsigned atten_to_gain(input longint unsigned att);
      longint unsigned n, f, y;
      n = att >> 16;
      f = att & 64'hFFFF;
      y = 64'd1 << 30;
      if (n >= 40) return 0;
      for (int k = 0; k < 16; k++)
         y = int_sqrt(((f >> k) & 1) ? (y << 29) : (y << 30));
      return (y + (64'd1 << (13 + n))) >> (14 + n);
   endfunction

   function automatic limited_sample_type limit_sample(input logic signed [SW-1:0] smp);
      longint              s, prod, res;
      longint unsigned     mag, c, thr, r, slope, le, lt, d, g;
      limited_sample_type  o;
      s = longint'(smp);
      mag = (s < 0) ? longint'(-s) : longint'(s);
      c = (mag > env_level) ? attack_reg : release_reg;
      env_level = (c * env_level + (65536 - c) * mag + 32768) >> 16;
      thr = (thr_reg == 0) ? 1 : thr_reg;
      g = slim_pkg::GAIN_UNITY;
      if (env_level > thr) begin
         r = (ratio_reg < slim_pkg::RATIO_MIN) ? slim_pkg::RATIO_MIN : ratio_reg;
         slope = 65536 - ((64'd1 << 24) / r);
         le = fixed_log2(env_level);
         lt = fixed_log2(thr);
         d = (le > lt) ? le - lt : 0;
         g = atten_to_gain((d * slope + 32768) >> 16);
      end
      prod = s * longint'(g);
      res = (prod + 32768) >>> 16;
      if (res > SMAX) res = SMAX;
      if (res < -SMAX - 1) res = -SMAX - 1;
      o.out = res[SW-1:0];
      o.gain = g[slim_pkg::GAIN_W-1:0];
      return o;
   endfunction

   // request side: register writes and accepted samples
   always @(posedge clock) begin
      limited_sample_type p;
      if (reset) begin
         thr_reg <= 23'(slim_pkg::THRESHOLD_RESET);
         attack_reg <= 16'(slim_pkg::ATTACK_RESET);
         release_reg <= 16'(slim_pkg::RELEASE_RESET);
         ratio_reg <= 16'(slim_pkg::RATIO_RESET);
         env_level = 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               slim_pkg::CSR_THRESHOLD: thr_reg <= csr_data[22:0];
               slim_pkg::CSR_ATTACK:    attack_reg <= csr_data[15:0];
               slim_pkg::CSR_RELEASE:   release_reg <= csr_data[15:0];
               slim_pkg::CSR_RATIO:     ratio_reg <= csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            p = limit_sample(req_sample_in);
            if (p.gain != slim_pkg::GAIN_UNITY) limited++;
            if (cur_typed) begin
               p.out = cur_out;
               p.gain = cur_gain;
            end
            expected_q.push_back(p);
            accepted++;
         end
      end
   end

   // result side
   always @(posedge clock) begin
      limited_sample_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transaction out=%0d gain=%0d", $time,
                     rsp_sample_out, rsp_gain_applied);
            errors++;
         end else begin
            e = expected_q.pop_front();
            checked++;
            if (rsp_sample_out !== e.out) begin
               $display("%0t: sample_out expected %0d actual %0d", $time,
                        e.out, rsp_sample_out);
               errors++;
            end
            if (rsp_gain_applied !== e.gain) begin
               $display("%0t: gain_applied expected %0d actual %0d", $time,
                        e.gain, rsp_gain_applied);
               errors++;
            end
         end
      end
   end

   // receiver stall, with one long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (3000) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      #60ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // called and returns at a falling edge
   task automatic send_sample(input logic signed [SW-1:0] smp, input bit typed = 0,
                              input logic signed [SW-1:0] out = '0,
                              input logic [slim_pkg::GAIN_W-1:0] gain = '0);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= smp;
      cur_typed = typed;
      cur_out = out;
      cur_gain = gain;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [slim_pkg::INDEX_W-1:0] idx,
                            input logic [CSR_W-1:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      cur_typed = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_idling(input idle_mode_type m);
      send_pct = (m == IDLE_SEND) ? 48 : (m == IDLE_BOTH) ? 26 : 0;
      stall_pct = (m == IDLE_RECV) ? 48 : (m == IDLE_BOTH) ? 26 : 0;
   endtask

   task automatic write_all(input logic [22:0] thr, input logic [15:0] atk,
                            input logic [15:0] rel, input logic [15:0] rat);
      write_reg(slim_pkg::CSR_THRESHOLD, CSR_W'(thr));
      write_reg(slim_pkg::CSR_ATTACK, CSR_W'(atk));
      write_reg(slim_pkg::CSR_RELEASE, CSR_W'(rel));
      write_reg(slim_pkg::CSR_RATIO, CSR_W'(rat));
   endtask

   function automatic logic signed [SW-1:0] scaled_sample(input int amp);
      int v;
      v = int'($urandom_range(amp));
      return ($urandom_range(1)) ? SW'(-v) : SW'(v);
   endfunction

   // loud and quiet passages of random length, with some noise mixed in
   task automatic random_passages(input int count);
      int n, seg, amp;
      n = 0;
      while (n < count) begin
         seg = $urandom_range(30, 4);
         case ($urandom_range(5))
            0: amp = $urandom_range(4000);
            1: amp = int'(thr_reg) + $urandom_range(SMAX - int'(thr_reg));
            2: amp = SMAX;
            3: amp = $urandom_range(SMAX);
            default: amp = int'(thr_reg) / 2 + $urandom_range(int'(thr_reg));
         endcase
         if (amp > SMAX) amp = SMAX;
         for (int i = 0; i < seg && n < count; i++, n++) begin
            case ($urandom_range(19))
               0: send_sample(SW'($urandom));
               1: send_sample($urandom_range(1) ? SW'(SMAX) : SW'(-SMAX - 1));
               default: send_sample(scaled_sample(amp));
            endcase
         end
      end
   endtask

   task automatic random_config();
      logic [22:0] thr;
      logic [15:0] atk, rel, rat;
      case ($urandom_range(5))
         0: thr = 0;
         1: thr = 23'h7FFFFF;
         default: thr = $urandom_range(8388607, 1);
      endcase
      case ($urandom_range(4))
         0: atk = 0;
         1: atk = 16'hFFFF;
         default: atk = $urandom_range(65535, 40000);
      endcase
      case ($urandom_range(4))
         0: rel = 0;
         1: rel = 16'hFFFF;
         default: rel = $urandom_range(65535, 50000);
      endcase
      case ($urandom_range(5))
         0: rat = $urandom_range(255);
         1: rat = 16'hFFFF;
         default: rat = $urandom_range(8000, 256);
      endcase
      write_all(thr, atk, rel, rat);
   endtask

   initial begin
      stim_row_type r;
      directed_rows.push_back('{24'sd0, 1'b1, 24'sd0, 17'd65536});
      directed_rows.push_back('{24'sd1000, 1'b1, 24'sd1000, 17'd65536});
      directed_rows.push_back('{-24'sd1000, 1'b1, -24'sd1000, 17'd65536});
      for (int i = 0; i < 6; i++)
         directed_rows.push_back('{SW'(SMAX), 1'b0, '0, '0});
      for (int i = 0; i < 6; i++)
         directed_rows.push_back('{SW'(-SMAX - 1), 1'b0, '0, '0});
      directed_rows.push_back('{24'sd1, 1'b0, '0, '0});
      directed_rows.push_back('{-24'sd1, 1'b0, '0, '0});
      directed_rows.push_back('{24'sd0, 1'b0, '0, '0});

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         send_sample(r.smp, r.typed, r.out, r.gain);
      end
      drain();

      // zero threshold, instant attack, slowest release, ratio below unity
      write_all(23'd0, 16'd0, 16'hFFFF, 16'd0);
      for (int i = 0; i < 4; i++) send_sample($urandom_range(1) ? SW'(SMAX) : SW'(-SMAX - 1));
      drain();
      // full-scale threshold, steepest ratio
      write_all(23'h7FFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
      for (int i = 0; i < 3; i++) send_sample(SW'(-SMAX - 1));
      drain();
      write_all(23'd1, 16'd0, 16'd0, 16'hFFFF);
      send_sample(SW'(SMAX));
      send_sample(SW'(-SMAX - 1));
      send_sample(24'sd1);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         random_config();
         set_idling(idle_mode_type'(ph % 4));
         if (ph == 5) hold_request = 1'b1;
         random_passages(190);
         drain();
      end
      set_idling(IDLE_NONE);
      drain();
      repeat (800) @(negedge clock);

      $display("%0d samples sent, %0d results checked, %0d with gain reduction",
               accepted, checked, limited);
      $display("over 12 register settings and four idling patterns");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
